// ===== rtl/asl_pkg.sv =====
`timescale 1ns / 1ps
// asl_pkg: shared types and constants of the assembly source lexer
// used by every module of the block; depends on nothing
package asl_pkg;

  // position counter width and output field width
  localparam int POS_W   = 16;
  localparam int OUT_W   = 16;
  localparam int OUT_MAX = 65535;

  // depth of the token queue between front and back
  localparam int QDEPTH = 4;
  localparam int QA_W   = $clog2(QDEPTH);

  // token kinds
  localparam logic [3:0] TK_NEWLINE = 4'd0;
  localparam logic [3:0] TK_DOT     = 4'd1;
  localparam logic [3:0] TK_COMMA   = 4'd2;
  localparam logic [3:0] TK_COLON   = 4'd3;
  localparam logic [3:0] TK_PLUS    = 4'd4;
  localparam logic [3:0] TK_MINUS   = 4'd5;
  localparam logic [3:0] TK_LPAR    = 4'd6;
  localparam logic [3:0] TK_RPAR    = 4'd7;
  localparam logic [3:0] TK_IDENT   = 4'd8;
  localparam logic [3:0] TK_INT     = 4'd9;
  localparam logic [3:0] TK_ERROR   = 4'd10;

  // input item kinds
  localparam logic IK_CHAR = 1'b0;
  localparam logic IK_EOS  = 1'b1;

  // character codes
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_UNDER = 8'h5f;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LB    = 8'h62;
  localparam logic [7:0] CH_UB    = 8'h42;
  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;

  typedef enum logic [2:0] {
    LM_IDLE,
    LM_COMMENT,
    LM_IDENT,
    LM_NUMFIRST,
    LM_NUMBER,
    LM_ERROR
  } lex_mode_t;

  typedef enum logic [1:0] {
    NB_DEC,
    NB_HEX,
    NB_BIN
  } num_base_t;

  // one finished token
  typedef struct packed {
    logic [3:0]       kind;
    logic [OUT_W-1:0] line;
    logic [OUT_W-1:0] col;
    logic [OUT_W-1:0] offset;
    logic [OUT_W-1:0] length;
  } token_t;

  // tokens caused by one input item, in order
  typedef struct packed {
    logic   two;
    token_t tok0;
    token_t tok1;
  } tok_entry_t;

endpackage

// ===== rtl/assembly_source_lexer.sv =====
`timescale 1ns / 1ps
// assembly_source_lexer: streaming tokenizer for assembly source text
// depends on asl_pkg, asl_front, asl_queue and asl_back
//
// Input channel: one character (in_kind 0) or end of source (in_kind 1)
// per request; a request is taken at a clock edge with in_push high and
// in_full low. Result channel: tokens with start line, column, offset and
// length; the oldest token is on the out_ ports while out_empty is low and
// is taken at an edge with out_pop high. out_last_of_run marks the final
// token caused by one input request; a request may cause none, one or two.
// A request is lexed in the cycle it is taken; its tokens pass the queue
// and output register. One request can be taken every cycle while in_full
// is low; the output register hands out one token per cycle, so bursts of
// two-token requests fill the four-entry queue, which then raises in_full.
// When the receiver stalls the current token holds and the queue fills.
// Reset clears the lexer state, positions, queue and output register; no
// clearing pass is needed, so the block takes requests right after reset.
module assembly_source_lexer
  import asl_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  output logic             in_full,
  input  logic             in_kind,
  input  logic [7:0]       in_char_code,
  output logic             out_empty,
  input  logic             out_pop,
  output logic [3:0]       out_token_kind,
  output logic [OUT_W-1:0] out_start_line,
  output logic [OUT_W-1:0] out_start_col,
  output logic [OUT_W-1:0] out_start_offset,
  output logic [OUT_W-1:0] out_token_length,
  output logic             out_last_of_run
);

  logic       accept;
  logic       ent_valid;
  tok_entry_t ent;
  tok_entry_t q_data;
  logic       q_full, q_empty, q_pop;
  token_t     out_tok;

  assign in_full = q_full;
  assign accept  = in_push && !q_full;

  // front: lexer state and token forming
  asl_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .in_kind      (in_kind),
    .in_char_code (in_char_code),
    .ent_valid    (ent_valid),
    .ent          (ent)
  );

  // queue between front and back
  asl_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (accept && ent_valid),
    .wr_data (ent),
    .full    (q_full),
    .pop     (q_pop),
    .empty   (q_empty),
    .rd_data (q_data)
  );

  // back: one token per cycle to the result ports while the receiver takes them
  asl_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_tok   (out_tok),
    .out_last  (out_last_of_run)
  );

  assign out_token_kind   = out_tok.kind;
  assign out_start_line   = out_tok.line;
  assign out_start_col    = out_tok.col;
  assign out_start_offset = out_tok.offset;
  assign out_token_length = out_tok.length;

endmodule

// ===== rtl/asl_front.sv =====
`timescale 1ns / 1ps
// asl_front: accepts characters, tracks the lexer state and positions,
// and forms the tokens of each item; depends on asl_pkg
module asl_front
  import asl_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic       in_kind,
  input  logic [7:0] in_char_code,
  output logic       ent_valid,
  output tok_entry_t ent
);

  lex_mode_t        mode_r, mode_nxt;
  num_base_t        base_r, base_nxt;
  logic [POS_W-1:0] cur_off_r, cur_off_nxt;
  logic [POS_W-1:0] cur_line_r, cur_line_nxt;
  logic [POS_W-1:0] cur_col_r, cur_col_nxt;
  logic [POS_W-1:0] tok_off_r, tok_off_nxt;
  logic [POS_W-1:0] tok_line_r, tok_line_nxt;
  logic [POS_W-1:0] tok_col_r, tok_col_nxt;
  logic             any_r, any_nxt;

  logic [7:0]       c;
  logic             is_dec, is_id, is_blank, is_nl, is_hex, is_bin;
  logic [3:0]       pk;
  logic             do_open, do_fresh, do_adv;
  logic [3:0]       open_kind;
  logic             fr_emit, fr_mark, fr_adv;
  logic [3:0]       fr_kind;
  logic [POS_W-1:0] fr_len;
  lex_mode_t        fr_mode;
  logic [POS_W-1:0] open_len;
  token_t           open_tok, fr_tok, eos_tok;
  logic             eos_nl;

  function automatic logic [POS_W-1:0] inc_pos(input logic [POS_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic logic [OUT_W-1:0] sat_out(input logic [POS_W-1:0] v);
    if (POS_W > OUT_W && v > POS_W'(OUT_MAX)) begin
      return '1;
    end
    return OUT_W'(v);
  endfunction

  // character classes
  assign c        = in_char_code;
  assign is_dec   = c inside {[8'h30:8'h39]};
  assign is_id    = (c inside {[8'h61:8'h7a], [8'h41:8'h5a]}) || c == CH_UNDER;
  assign is_blank = c == CH_SPACE || c == CH_TAB || c == CH_CR;
  assign is_nl    = c == CH_NL;
  assign is_hex   = is_dec || (c inside {[8'h61:8'h66], [8'h41:8'h46]});
  assign is_bin   = c == CH_ZERO || c == CH_ONE;

  always_comb begin
    case (c)
      8'h2e:   pk = TK_DOT;
      8'h2c:   pk = TK_COMMA;
      8'h3a:   pk = TK_COLON;
      8'h2b:   pk = TK_PLUS;
      8'h2d:   pk = TK_MINUS;
      8'h28:   pk = TK_LPAR;
      8'h29:   pk = TK_RPAR;
      default: pk = TK_NEWLINE;
    endcase
  end

  // what a character does when no token is open
  always_comb begin
    fr_emit = 1'b0;
    fr_mark = 1'b0;
    fr_adv  = 1'b1;
    fr_kind = TK_NEWLINE;
    fr_len  = (cur_off_r == '1) ? '0 : POS_W'(1);
    fr_mode = LM_IDLE;
    if (c == CH_HASH) begin
      fr_mode = LM_COMMENT;
    end else if (is_nl || pk != TK_NEWLINE) begin
      fr_emit = 1'b1;
      fr_mark = 1'b1;
      fr_kind = pk;
    end else if (is_id) begin
      fr_mark = 1'b1;
      fr_mode = LM_IDENT;
    end else if (is_dec) begin
      fr_mark = 1'b1;
      fr_mode = LM_NUMFIRST;
    end else if (!is_blank) begin
      fr_emit = 1'b1;
      fr_adv  = 1'b0;
      fr_kind = TK_ERROR;
      fr_len  = '0;
      fr_mode = LM_ERROR;
    end
  end

  // open token length and the token records
  assign open_len = (cur_off_r >= tok_off_r) ? cur_off_r - tok_off_r : '0;

  always_comb begin
    open_tok.kind   = open_kind;
    open_tok.line   = sat_out(tok_line_r);
    open_tok.col    = sat_out(tok_col_r);
    open_tok.offset = sat_out(tok_off_r);
    open_tok.length = sat_out(open_len);
    fr_tok.kind     = fr_kind;
    fr_tok.line     = sat_out(cur_line_r);
    fr_tok.col      = sat_out(cur_col_r);
    fr_tok.offset   = sat_out(cur_off_r);
    fr_tok.length   = sat_out(fr_len);
    eos_tok         = '0;
    eos_tok.kind    = TK_NEWLINE;
  end

  // lexer step
  always_comb begin
    do_open   = 1'b0;
    do_fresh  = 1'b0;
    do_adv    = 1'b0;
    open_kind = TK_IDENT;
    eos_nl    = 1'b0;
    base_nxt  = base_r;
    mode_nxt  = mode_r;
    if (in_kind == IK_EOS) begin
      case (mode_r)
        LM_IDENT: begin
          do_open = 1'b1;
        end
        LM_NUMFIRST, LM_NUMBER: begin
          do_open   = 1'b1;
          open_kind = TK_INT;
        end
        default: begin
          eos_nl = !any_r;
        end
      endcase
    end else begin
      case (mode_r)
        LM_ERROR: begin
        end
        LM_COMMENT: begin
          if (is_nl) begin
            do_fresh = 1'b1;
          end else begin
            do_adv = 1'b1;
          end
        end
        LM_IDENT: begin
          if (is_id || is_dec) begin
            do_adv = 1'b1;
          end else begin
            do_open  = 1'b1;
            do_fresh = 1'b1;
          end
        end
        LM_NUMFIRST: begin
          mode_nxt = LM_NUMBER;
          if (c == CH_LX || c == CH_UX) begin
            base_nxt = NB_HEX;
            do_adv   = 1'b1;
          end else if (c == CH_LB || c == CH_UB) begin
            base_nxt = NB_BIN;
            do_adv   = 1'b1;
          end else if (is_dec || c == CH_UNDER) begin
            do_adv = 1'b1;
          end else begin
            open_kind = TK_INT;
            do_open   = 1'b1;
            do_fresh  = 1'b1;
          end
        end
        LM_NUMBER: begin
          if (c == CH_UNDER || (base_r == NB_HEX && is_hex) ||
              (base_r == NB_BIN && is_bin) || (base_r == NB_DEC && is_dec)) begin
            do_adv = 1'b1;
          end else begin
            open_kind = TK_INT;
            do_open   = 1'b1;
            do_fresh  = 1'b1;
          end
        end
        default: begin
          do_fresh = 1'b1;
        end
      endcase
      if (do_fresh) begin
        mode_nxt = fr_mode;
        if (fr_mode == LM_NUMFIRST) begin
          base_nxt = NB_DEC;
        end
      end
    end
  end

  // queue entry for this item
  always_comb begin
    ent       = '0;
    ent_valid = 1'b0;
    if (do_open) begin
      ent.tok0  = open_tok;
      ent_valid = 1'b1;
      if (do_fresh && fr_emit) begin
        ent.tok1 = fr_tok;
        ent.two  = 1'b1;
      end
    end else if (do_fresh && fr_emit) begin
      ent.tok0  = fr_tok;
      ent_valid = 1'b1;
    end else if (eos_nl) begin
      ent.tok0  = eos_tok;
      ent_valid = 1'b1;
    end
  end

  // position and token start update
  always_comb begin
    cur_off_nxt  = cur_off_r;
    cur_line_nxt = cur_line_r;
    cur_col_nxt  = cur_col_r;
    tok_off_nxt  = tok_off_r;
    tok_line_nxt = tok_line_r;
    tok_col_nxt  = tok_col_r;
    any_nxt      = any_r || ent_valid;
    if (in_kind == IK_EOS) begin
      cur_off_nxt  = '0;
      cur_line_nxt = '0;
      cur_col_nxt  = '0;
      tok_off_nxt  = '0;
      tok_line_nxt = '0;
      tok_col_nxt  = '0;
      any_nxt      = 1'b0;
    end else begin
      if (do_fresh && fr_mark) begin
        tok_off_nxt  = cur_off_r;
        tok_line_nxt = cur_line_r;
        tok_col_nxt  = cur_col_r;
      end
      if (do_adv || (do_fresh && fr_adv)) begin
        cur_off_nxt = inc_pos(cur_off_r);
        if (is_nl) begin
          cur_line_nxt = inc_pos(cur_line_r);
          cur_col_nxt  = '0;
        end else begin
          cur_col_nxt = inc_pos(cur_col_r);
        end
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= LM_IDLE;
      base_r     <= NB_DEC;
      cur_off_r  <= '0;
      cur_line_r <= '0;
      cur_col_r  <= '0;
      tok_off_r  <= '0;
      tok_line_r <= '0;
      tok_col_r  <= '0;
      any_r      <= 1'b0;
    end else if (accept) begin
      mode_r     <= (in_kind == IK_EOS) ? LM_IDLE : mode_nxt;
      base_r     <= (in_kind == IK_EOS) ? NB_DEC : base_nxt;
      cur_off_r  <= cur_off_nxt;
      cur_line_r <= cur_line_nxt;
      cur_col_r  <= cur_col_nxt;
      tok_off_r  <= tok_off_nxt;
      tok_line_r <= tok_line_nxt;
      tok_col_r  <= tok_col_nxt;
      any_r      <= any_nxt;
    end
  end

endmodule

// ===== rtl/asl_queue.sv =====
`timescale 1ns / 1ps
// asl_queue: short register queue of token entries between front and back
// depends on asl_pkg
module asl_queue
  import asl_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  tok_entry_t wr_data,
  output logic       full,
  input  logic       pop,
  output logic       empty,
  output tok_entry_t rd_data
);

  tok_entry_t      store_r [QDEPTH];
  logic [QA_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QA_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QA_W:0]   count_r, count_nxt;
  logic            do_push, do_pop;

  assign full    = count_r == (QA_W+1)'(QDEPTH);
  assign empty   = count_r == '0;
  assign rd_data = store_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ===== rtl/asl_back.sv =====
`timescale 1ns / 1ps
// asl_back: takes token entries from the queue and hands them out one token
// at a time through the output register; depends on asl_pkg
module asl_back
  import asl_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  input  tok_entry_t q_data,
  output logic       q_pop,
  output logic       out_empty,
  input  logic       out_pop,
  output token_t     out_tok,
  output logic       out_last
);

  logic   sel_r, sel_nxt;
  logic   valid_r, valid_nxt;
  token_t tok_r, tok_nxt;
  logic   last_r, last_nxt;
  logic   load;

  // load the output register when it is free or being taken
  assign load = !q_empty && (!valid_r || out_pop);

  always_comb begin
    sel_nxt   = sel_r;
    tok_nxt   = tok_r;
    last_nxt  = last_r;
    q_pop     = 1'b0;
    valid_nxt = valid_r && !out_pop;
    if (load) begin
      valid_nxt = 1'b1;
      tok_nxt   = sel_r ? q_data.tok1 : q_data.tok0;
      last_nxt  = sel_r || !q_data.two;
      if (sel_r || !q_data.two) begin
        q_pop   = 1'b1;
        sel_nxt = 1'b0;
      end else begin
        sel_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r   <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      sel_r   <= sel_nxt;
      valid_r <= valid_nxt;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    tok_r  <= tok_nxt;
    last_r <= last_nxt;
  end

  assign out_empty = !valid_r;
  assign out_tok   = tok_r;
  assign out_last  = last_r;

endmodule

// ===== rtl/asl_checker.sv =====
`timescale 1ns / 1ps
// asl_checker: port-level checks of the assembly source lexer, bound to the
// top level; depends on asl_pkg
module asl_checker
  import asl_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             out_empty,
  input logic             out_pop,
  input logic [3:0]       out_token_kind,
  input logic [OUT_W-1:0] out_start_offset,
  input logic [OUT_W-1:0] out_token_length,
  input logic             out_last_of_run
);

  // nothing waits on the result side right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result present after reset");

  // a stalled token holds its kind and position
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_token_kind) &&
      $stable(out_start_offset) && $stable(out_last_of_run))
    else $error("stalled token changed");

  // only defined token kinds leave the block
  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_token_kind <= TK_ERROR)
    else $error("undefined token kind");

  // an error token covers no characters
  a_error_len: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_token_kind == TK_ERROR |-> out_token_length == '0)
    else $error("error token with nonzero length");

  // newline and punctuation tokens are at most one character long
  a_single_len: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_token_kind <= TK_RPAR |-> out_token_length <= OUT_W'(1))
    else $error("single-character token too long");

endmodule

bind assembly_source_lexer asl_checker u_asl_checker (.*);

// ===== sim/assembly_source_lexer_tb.sv =====
`timescale 1ns / 1ps
// assembly_source_lexer_tb: self-checking bench for the assembly source lexer
// drives character and end-of-source requests, predicts the tokens in-bench
// depends on asl_pkg and assembly_source_lexer
module assembly_source_lexer_tb;
  import asl_pkg::*;

  localparam int CYCLE_LIMIT    = 1500000;
  localparam int DRAIN_LIMIT    = 5000;
  localparam int RAND_PER_PHASE = 150;
  localparam int PRINT_CAP      = 40;
  localparam logic [POS_W-1:0] POS_TOP = '1;

  // one expected token and its end-of-request flag
  typedef struct packed {
    token_t tok;
    logic   last;
  } lexeme_t;

  // one request, optionally with its single token written out by hand
  typedef struct packed {
    logic       kind;
    logic [7:0] ch;
    logic       typed;
    lexeme_t    want;
  } lex_req_t;

  logic             clk;
  logic             rst_n        = 1'b0;
  logic             in_push      = 1'b0;
  logic             in_full;
  logic             in_kind      = IK_CHAR;
  logic [7:0]       in_char_code = 8'h00;
  logic             out_empty;
  logic             out_pop      = 1'b0;
  logic [3:0]       out_token_kind;
  logic [OUT_W-1:0] out_start_line;
  logic [OUT_W-1:0] out_start_col;
  logic [OUT_W-1:0] out_start_offset;
  logic [OUT_W-1:0] out_token_length;
  logic             out_last_of_run;

  assembly_source_lexer dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_kind          (in_kind),
    .in_char_code     (in_char_code),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_token_kind   (out_token_kind),
    .out_start_line   (out_start_line),
    .out_start_col    (out_start_col),
    .out_start_offset (out_start_offset),
    .out_token_length (out_token_length),
    .out_last_of_run  (out_last_of_run)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  lex_req_t char_q [$];
  lex_req_t dir_rows [$];
  lexeme_t  pending_tokens [$];
  lex_req_t cur_req;
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  int       gen_count;
  int       mismatches = 0;
  int       cycle_count = 0;

  // predictor state
  lex_mode_t        mode;
  num_base_t        base;
  logic [POS_W-1:0] cur_off, cur_line, cur_col;
  logic [POS_W-1:0] tok_off, tok_line, tok_col;
  logic             emitted;
  token_t           step_tok [2];
  int               step_n;

  // mismatch report
  task automatic flag_mismatch(input string field, input int got, input int want);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("%0t ns mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
  endtask

  // character classes
  function automatic logic is_dec(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_ident_start(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDER;
  endfunction

  function automatic logic is_base_digit(input logic [7:0] c, input num_base_t b);
    if (b == NB_HEX)
      return is_dec(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    if (b == NB_BIN)
      return c == CH_ZERO || c == CH_ONE;
    return is_dec(c);
  endfunction

  // punctuation kind, newline kind when the character is none
  function automatic logic [3:0] punct_of(input logic [7:0] c);
    case (c)
      ".":     return TK_DOT;
      ",":     return TK_COMMA;
      ":":     return TK_COLON;
      "+":     return TK_PLUS;
      "-":     return TK_MINUS;
      "(":     return TK_LPAR;
      ")":     return TK_RPAR;
      default: return TK_NEWLINE;
    endcase
  endfunction

  function automatic logic [POS_W-1:0] bump(input logic [POS_W-1:0] v);
    return (v == POS_TOP) ? v : v + 1'b1;
  endfunction

  task automatic reset_lexer();
    mode     = LM_IDLE;
    base     = NB_DEC;
    cur_off  = '0;
    cur_line = '0;
    cur_col  = '0;
    tok_off  = '0;
    tok_line = '0;
    tok_col  = '0;
    emitted  = 1'b0;
  endtask

  task automatic step_over(input logic [7:0] c);
    cur_off = bump(cur_off);
    if (c == CH_NL) begin
      cur_line = bump(cur_line);
      cur_col  = '0;
    end else begin
      cur_col = bump(cur_col);
    end
  endtask

  task automatic mark_tok();
    tok_off  = cur_off;
    tok_line = cur_line;
    tok_col  = cur_col;
  endtask

  task automatic emit(input logic [3:0] k, input logic [POS_W-1:0] line,
                      input logic [POS_W-1:0] col, input logic [POS_W-1:0] off,
                      input logic [POS_W-1:0] len);
    step_tok[step_n].kind   = k;
    step_tok[step_n].line   = line;
    step_tok[step_n].col    = col;
    step_tok[step_n].offset = off;
    step_tok[step_n].length = len;
    step_n++;
    emitted = 1'b1;
  endtask

  // close the token that started at the marked position
  task automatic emit_open(input logic [3:0] k);
    emit(k, tok_line, tok_col, tok_off, (cur_off >= tok_off) ? cur_off - tok_off : '0);
  endtask

  // lex one character with no token open
  task automatic lex_fresh(input logic [7:0] c);
    logic [3:0] pk;
    pk   = punct_of(c);
    mode = LM_IDLE;
    if (c == CH_HASH) begin
      step_over(c);
      mode = LM_COMMENT;
    end else if (c == CH_NL) begin
      mark_tok();
      step_over(c);
      emit_open(TK_NEWLINE);
    end else if (pk != TK_NEWLINE) begin
      mark_tok();
      step_over(c);
      emit_open(pk);
    end else if (is_ident_start(c)) begin
      mark_tok();
      step_over(c);
      mode = LM_IDENT;
    end else if (is_dec(c)) begin
      mark_tok();
      step_over(c);
      base = NB_DEC;
      mode = LM_NUMFIRST;
    end else if (c == CH_SPACE || c == CH_TAB || c == CH_CR) begin
      step_over(c);
    end else begin
      emit(TK_ERROR, cur_line, cur_col, cur_off, '0);
      mode = LM_ERROR;
    end
  endtask

  // tokens caused by one request, left in step_tok[0 .. step_n-1]
  task automatic lex_char(input logic kind, input logic [7:0] c);
    step_n = 0;
    if (kind == IK_EOS) begin
      if (mode == LM_IDENT)
        emit_open(TK_IDENT);
      else if (mode == LM_NUMFIRST || mode == LM_NUMBER)
        emit_open(TK_INT);
      if (!emitted)
        emit(TK_NEWLINE, '0, '0, '0, '0);
      reset_lexer();
    end else begin
      case (mode)
        LM_ERROR: begin
        end
        LM_COMMENT: begin
          if (c == CH_NL)
            lex_fresh(c);
          else
            step_over(c);
        end
        LM_IDENT: begin
          if (is_ident_start(c) || is_dec(c)) begin
            step_over(c);
          end else begin
            emit_open(TK_IDENT);
            lex_fresh(c);
          end
        end
        LM_NUMFIRST, LM_NUMBER: begin
          if (mode == LM_NUMFIRST && (c == CH_LX || c == CH_UX)) begin
            base = NB_HEX;
            mode = LM_NUMBER;
            step_over(c);
          end else if (mode == LM_NUMFIRST && (c == CH_LB || c == CH_UB)) begin
            base = NB_BIN;
            mode = LM_NUMBER;
            step_over(c);
          end else begin
            mode = LM_NUMBER;
            if (is_base_digit(c, base) || c == CH_UNDER) begin
              step_over(c);
            end else begin
              emit_open(TK_INT);
              lex_fresh(c);
            end
          end
        end
        default: lex_fresh(c);
      endcase
    end
  endtask

  // request builders for the directed table
  function automatic lex_req_t chr(input logic [7:0] c);
    lex_req_t r;
    r      = '0;
    r.kind = IK_CHAR;
    r.ch   = c;
    return r;
  endfunction

  function automatic lex_req_t eos();
    lex_req_t r;
    r      = '0;
    r.kind = IK_EOS;
    return r;
  endfunction

  function automatic lex_req_t typed_as(input lex_req_t r, input logic [3:0] k,
                                        input logic [POS_W-1:0] line,
                                        input logic [POS_W-1:0] col,
                                        input logic [POS_W-1:0] off,
                                        input logic [POS_W-1:0] len);
    lex_req_t t;
    t                  = r;
    t.typed            = 1'b1;
    t.want.tok.kind    = k;
    t.want.tok.line    = line;
    t.want.tok.col     = col;
    t.want.tok.offset  = off;
    t.want.tok.length  = len;
    t.want.last        = 1'b1;
    return t;
  endfunction

  task automatic queue_char(input logic [7:0] c);
    char_q.insert(char_q.size(), chr(c));
    gen_count++;
  endtask

  // random characters
  function automatic logic [7:0] rand_letter();
    int r;
    r = $urandom_range(51);
    return (r < 26) ? 8'("a" + r) : 8'("A" + r - 26);
  endfunction

  function automatic logic [7:0] rand_hex_digit();
    int r;
    r = $urandom_range(21);
    if (r < 10)
      return 8'("0" + r);
    if (r < 16)
      return 8'("a" + r - 10);
    return 8'("A" + r - 16);
  endfunction

  function automatic logic [7:0] rand_ident_char();
    int r;
    r = $urandom_range(63);
    if (r < 52)
      return rand_letter();
    if (r < 62)
      return 8'("0" + r - 52);
    return CH_UNDER;
  endfunction

  // one random source of mostly well-formed tokens, closed by end of source
  task automatic gen_source();
    int         ntok, r, len, style;
    logic [7:0] c;
    ntok = $urandom_range(12, 1);
    for (int t = 0; t < ntok; t++) begin
      r = $urandom_range(99);
      if (r < 22) begin
        queue_char(($urandom_range(9) == 0) ? CH_UNDER : rand_letter());
        len = $urandom_range(5);
        repeat (len) queue_char(rand_ident_char());
      end else if (r < 44) begin
        queue_char(8'("0" + $urandom_range(9)));
        style = $urandom_range(2);
        if (style == 1)
          queue_char($urandom_range(1) ? CH_LX : CH_UX);
        else if (style == 2)
          queue_char($urandom_range(1) ? CH_LB : CH_UB);
        len = $urandom_range(5);
        repeat (len) begin
          if ($urandom_range(99) < 15)
            c = CH_UNDER;
          else if (style == 1)
            c = rand_hex_digit();
          else if (style == 2)
            c = ($urandom_range(19) == 0) ? 8'("2") : 8'("0" + $urandom_range(1));
          else
            c = 8'("0" + $urandom_range(9));
          queue_char(c);
        end
      end else if (r < 64 || (r >= 92 && r < 97)) begin
        case ($urandom_range(6))
          0:       queue_char(".");
          1:       queue_char(",");
          2:       queue_char(":");
          3:       queue_char("+");
          4:       queue_char("-");
          5:       queue_char("(");
          default: queue_char(")");
        endcase
      end else if (r < 74) begin
        case ($urandom_range(2))
          0:       queue_char(CH_SPACE);
          1:       queue_char(CH_TAB);
          default: queue_char(CH_CR);
        endcase
      end else if (r < 84) begin
        queue_char(CH_NL);
      end else if (r < 92) begin
        queue_char(CH_HASH);
        len = $urandom_range(6);
        repeat (len) begin
          c = 8'($urandom_range(255));
          queue_char((c == CH_NL) ? CH_SPACE : c);
        end
        if ($urandom_range(99) < 80)
          queue_char(CH_NL);
      end else begin
        queue_char(8'($urandom_range(255)));
      end
    end
    // occasional unknown character, then a few ignored ones
    if ($urandom_range(99) < 8) begin
      queue_char(8'($urandom_range(255, 128)));
      len = $urandom_range(3);
      repeat (len) queue_char(8'($urandom_range(255)));
    end
    char_q.insert(char_q.size(), eos());
    gen_count++;
  endtask

  // wait until every request is taken and every token has come back
  task automatic drain();
    int waited;
    waited = 0;
    while (char_q.size() != 0 || in_push)
      @(negedge clk);
    while (pending_tokens.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (8) @(negedge clk);
  endtask

  // request side, result side and checking
  always @(posedge clk) begin : handshake
    lex_req_t nxt;
    lexeme_t  exp_tok;
    lexeme_t  got_tok;
    if (!rst_n) begin
      in_push <= 1'b0;
      out_pop <= 1'b0;
    end else begin
      // accepted request: predict its tokens
      if (in_push && !in_full) begin
        lex_char(cur_req.kind, cur_req.ch);
        if (cur_req.typed) begin
          pending_tokens.insert(pending_tokens.size(), cur_req.want);
        end else begin
          for (int i = 0; i < step_n; i++) begin
            exp_tok.tok  = step_tok[i];
            exp_tok.last = (i == step_n - 1);
            pending_tokens.insert(pending_tokens.size(), exp_tok);
          end
        end
      end
      // next request, held while the lexer is full
      if (!(in_push && in_full)) begin
        if (char_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt          = char_q.pop_front();
          cur_req      <= nxt;
          in_push      <= 1'b1;
          in_kind      <= nxt.kind;
          in_char_code <= nxt.ch;
        end else begin
          in_push <= 1'b0;
        end
      end
      // accepted token: compare with the oldest prediction
      if (out_pop && !out_empty) begin
        if (pending_tokens.size() == 0) begin
          flag_mismatch("unexpected token, kind", out_token_kind, -1);
        end else begin
          exp_tok = pending_tokens.pop_front();
          got_tok.tok.kind   = out_token_kind;
          got_tok.tok.line   = out_start_line;
          got_tok.tok.col    = out_start_col;
          got_tok.tok.offset = out_start_offset;
          got_tok.tok.length = out_token_length;
          got_tok.last       = out_last_of_run;
          if (got_tok.tok.kind !== exp_tok.tok.kind)
            flag_mismatch("token_kind", got_tok.tok.kind, exp_tok.tok.kind);
          if (got_tok.tok.line !== exp_tok.tok.line)
            flag_mismatch("start_line", got_tok.tok.line, exp_tok.tok.line);
          if (got_tok.tok.col !== exp_tok.tok.col)
            flag_mismatch("start_col", got_tok.tok.col, exp_tok.tok.col);
          if (got_tok.tok.offset !== exp_tok.tok.offset)
            flag_mismatch("start_offset", got_tok.tok.offset, exp_tok.tok.offset);
          if (got_tok.tok.length !== exp_tok.tok.length)
            flag_mismatch("token_length", got_tok.tok.length, exp_tok.tok.length);
          if (got_tok.last !== exp_tok.last)
            flag_mismatch("last_of_run", got_tok.last, exp_tok.last);
        end
      end
      out_pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // test sequence
  initial begin
    reset_lexer();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table
    dir_rows = '{
      // empty source right after reset
      typed_as(eos(), TK_NEWLINE, '0, '0, '0, '0),
      // identifier closed by punctuation
      chr("a"), chr("9"), chr(","),
      // hex integer with underscore
      chr("0"), chr(CH_LX), chr("F"), chr(CH_UNDER), chr(":"),
      // binary prefix with no binary digit after it
      chr("1"), chr(CH_UB), chr("2"), chr("+"),
      // comment up to the newline
      chr(CH_HASH), chr(CH_SPACE), chr(CH_NL),
      // blanks, the remaining marks, integer closed by end of source
      chr(CH_TAB), chr("("), chr(")"), chr("-"), chr("."), chr(CH_CR), chr("7"), eos(),
      // unknown character, then everything ignored
      chr(CH_SPACE), typed_as(chr(8'h00), TK_ERROR, '0, POS_W'(1), POS_W'(1), '0),
      chr(8'hff), eos()
    };
    foreach (dir_rows[i])
      char_q.insert(char_q.size(), dir_rows[i]);
    drain();

    // random sources under each idling pattern
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 74;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 74;
        end
        default: begin
          send_idle_pct  = 37;
          recv_stall_pct = 37;
        end
      endcase
      gen_count = 0;
      while (gen_count < RAND_PER_PHASE)
        gen_source();
      drain();
    end

    if (pending_tokens.size() != 0)
      flag_mismatch("tokens never delivered", 0, pending_tokens.size());
    if (mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
